// ----- rtl/core/pcmv_pkg.sv -----
// Shared constants for the per-channel mean and variance block.
`default_nettype none
package pcmv_pkg;
    localparam int CHANNELS  = 256;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int SMP_W     = 16;
    localparam int CNT_W     = 25;
    localparam int SUM_W     = 41;
    localparam int SQ_W      = 55;
    localparam int ENTRY_W   = CNT_W + SUM_W + SQ_W + 1;
    localparam int MAX_COUNT = 16777216;
    localparam int VAR_W     = 30;
    localparam int DIVD_W    = SQ_W;
    localparam int DIVS_W    = CNT_W;
    localparam int MEAN_W    = 17;
    localparam int MPROD_W   = MEAN_W + SUM_W + 1;
    localparam int SQR_W     = 2 * CNT_W;
endpackage
`default_nettype wire

// ----- rtl/core/per_channel_mean_variance.sv -----
// Top level: per-channel count, mean and variance over a sample stream.
//
// Command channel: an item is taken when start is high and busy is low.
// i_req_type 0 adds i_sample (signed Q8.8) to channel i_channel; 1 reads
// the channel out and clears it.
// Result channel: a readout gives one result, shown for one cycle with
// o_valid high; the receiver cannot stall it. Accumulates give none.
// Sequencing: an accumulate holds busy through the S_ACC state (read of the
// statistics RAM, then add and write back), so the next item is taken only
// once the write back is done. A readout of a non-empty channel steps
// through S_RD, S_D1, S_FIX, S_MUL, S_SUBA, S_D2, S_CMP and S_FIN, with two
// passes of the 55-step serial divider (mean in S_D1, then variance in S_D2);
// an empty channel shows it straight from S_RD. Busy drops together with o_valid.
// Busy covers the whole read-modify-write, so no two accesses to one entry
// ever overlap.
// Reset: i_rst_n (synchronous) starts a clearing pass that writes zero to
// all 256 entries, one a cycle; busy stays high throughout the pass.
// Variance is floor((n*sumsq - sum^2)/n^2), Q16.16, saturated at 2^30-1.
`default_nettype none
module per_channel_mean_variance
    import pcmv_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_req_type,
    input  wire logic [CH_W-1:0]         i_channel,
    input  wire logic signed [SMP_W-1:0] i_sample,
    output logic                         o_valid,
    output logic      [CH_W-1:0]         o_out_channel,
    output logic      [CNT_W-1:0]        o_element_count,
    output logic signed [SMP_W-1:0]      o_mean_value,
    output logic      [VAR_W-1:0]        o_variance_value,
    output logic                         o_overflow
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ACC, S_RD, S_D1, S_FIX, S_MUL, S_SUBA, S_D2, S_CMP, S_FIN
    } t_state;

    t_state r_state;
    logic [CH_W-1:0]           r_clr_idx;
    logic                      r_req;
    logic [CH_W-1:0]           r_ch;
    logic signed [SMP_W-1:0]   r_x;
    logic [2*SMP_W-1:0]        r_sq;
    logic [CNT_W-1:0]          r_n;
    logic signed [SUM_W-1:0]   r_sum;
    logic [SQ_W-1:0]           r_sumsq;
    logic                      r_ovf;
    logic signed [MEAN_W-1:0]  r_q;
    logic [CNT_W-1:0]          r_r;
    logic signed [MPROD_W-1:0] r_prod;
    logic [SQ_W-1:0]           r_a;
    logic [SQR_W-1:0]          r_bn;
    logic [SQR_W-1:0]          r_rr;
    logic                      r_div_go;

    // RAM entry: {overflow mark, sum of squares, sum, count}
    logic               we;
    logic [CH_W-1:0]    waddr;
    logic [CH_W-1:0]    raddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [CNT_W-1:0]   rd_n;
    logic signed [SUM_W-1:0] rd_sum;
    logic [SQ_W-1:0]    rd_sumsq;
    logic               rd_ovf;

    assign rd_n     = rdata[CNT_W-1:0];
    assign rd_sum   = rdata[CNT_W +: SUM_W];
    assign rd_sumsq = rdata[CNT_W+SUM_W +: SQ_W];
    assign rd_ovf   = rdata[ENTRY_W-1];

    logic                 sat;
    logic [ENTRY_W-1:0]   acc_word;
    assign sat = rd_n >= CNT_W'(MAX_COUNT);
    always_comb begin
        if (sat) begin
            acc_word = {1'b1, rd_sumsq, rd_sum, rd_n};
        end else begin
            acc_word = {rd_ovf, rd_sumsq + SQ_W'(r_sq),
                        rd_sum + SUM_W'(r_x), rd_n + 1'b1};
        end
    end

    assign we    = (r_state == S_CLR) || (r_state == S_ACC) || (r_state == S_RD);
    assign waddr = (r_state == S_CLR) ? r_clr_idx : r_ch;
    assign wdata = (r_state == S_ACC) ? acc_word : '0;
    assign raddr = i_channel;

    pcmv_ram #(.WIDTH(ENTRY_W), .DEPTH(CHANNELS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Shared divider: |sum| / n first, then A / n.
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;
    logic [DIVS_W-1:0] div_rem;
    logic [DIVD_W-1:0] div_dvd;
    logic [SUM_W-1:0]  sum_mag;

    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign div_dvd = (r_state == S_D1) ? DIVD_W'(sum_mag) : r_a;

    pcmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (div_dvd),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // floor correction of the signed mean
    logic signed [MEAN_W-1:0] q_mag;
    assign q_mag = MEAN_W'(div_quo);

    logic signed [SUM_W:0] sum_plus_r;
    assign sum_plus_r = {r_sum[SUM_W-1], r_sum} + $signed({1'b0, SUM_W'(r_r)});

    logic [SQ_W-1:0] var_full;
    always_comb begin
        var_full = r_a;
        if (r_bn < r_rr && r_a != '0) begin
            var_full = r_a - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_div_go  <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            o_valid  <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == CH_W'(CHANNELS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req_type;
                        r_ch    <= i_channel;
                        r_x     <= i_sample;
                        r_sq    <= (2*SMP_W)'(i_sample * i_sample);
                        r_state <= i_req_type ? S_RD : S_ACC;
                    end
                end
                S_ACC: begin
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    r_n     <= rd_n;
                    r_sum   <= rd_sum;
                    r_sumsq <= rd_sumsq;
                    r_ovf   <= rd_ovf;
                    if (rd_n == '0) begin
                        o_valid          <= 1'b1;
                        o_out_channel    <= r_ch;
                        o_element_count  <= '0;
                        o_mean_value     <= '0;
                        o_variance_value <= '0;
                        o_overflow       <= rd_ovf;
                        r_state          <= S_IDLE;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= S_D1;
                    end
                end
                S_D1: begin
                    if (div_done) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (!r_sum[SUM_W-1]) begin
                        r_q <= q_mag;
                        r_r <= div_rem;
                    end else if (div_rem == '0) begin
                        r_q <= -q_mag;
                        r_r <= '0;
                    end else begin
                        r_q <= -q_mag - 1'b1;
                        r_r <= r_n - div_rem;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= MPROD_W'(r_q * sum_plus_r);
                    r_state <= S_SUBA;
                end
                S_SUBA: begin
                    r_a      <= SQ_W'($signed({1'b0, r_sumsq}) - r_prod);
                    r_div_go <= 1'b1;
                    r_state  <= S_D2;
                end
                S_D2: begin
                    if (div_done) begin
                        r_a     <= div_quo;
                        r_bn    <= SQR_W'(div_rem * r_n);
                        r_rr    <= SQR_W'(r_r * r_r);
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    o_valid         <= 1'b1;
                    o_out_channel   <= r_ch;
                    o_element_count <= r_n;
                    o_mean_value    <= r_q[SMP_W-1:0];
                    o_overflow      <= r_ovf;
                    if (var_full > SQ_W'({VAR_W{1'b1}})) begin
                        o_variance_value <= {VAR_W{1'b1}};
                    end else begin
                        o_variance_value <= var_full[VAR_W-1:0];
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

    // r_req is kept for the readout path checks below
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result shown while busy");
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");
    a_valid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_req) else $error("result from an accumulate");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_element_count <= CNT_W'(MAX_COUNT)))
        else $error("count above saturation");
endmodule
`default_nettype wire

// ----- rtl/core/pcmv_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module pcmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/pcmv_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module pcmv_div
    import pcmv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [DIVS_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [DIVD_W-1:0] o_quo,
    output logic      [DIVS_W-1:0] o_rem
);
    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [STEP_W-1:0] r_steps;
    logic              r_run;
    logic [DIVS_W:0]   r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;
    logic [DIVS_W:0]   shifted;
    logic              take;

    assign shifted = {r_rem[DIVS_W-1:0], r_quo[DIVD_W-1]};
    assign take    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_steps <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_steps <= STEP_W'(DIVD_W);
                r_rem   <= '0;
                r_quo   <= i_dividend;
                r_dvs   <= i_divisor;
            end else if (r_run) begin
                r_rem   <= take ? shifted - {1'b0, r_dvs} : shifted;
                r_quo   <= {r_quo[DIVD_W-2:0], take};
                r_steps <= r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_quo;
    assign o_rem = r_rem[DIVS_W-1:0];
endmodule
`default_nettype wire
